/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module of the sorter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/isort_pkg.sv */
// Package of the insertion sorter: widths, defaults and the cell control struct.
// No dependencies.
package isort_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 16;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic load;       // insert the broadcast value into the ordered row
    logic shift_out;  // move every entry one place toward cell zero
  } cell_ctrl_t;

endpackage

/* hw/rtl/isort_cell.sv */
// One compare-and-shift cell of the insertion sorter chain.
// Depends on isort_pkg.
module isort_cell
  import isort_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic                     occupied,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic                     left_gt,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value,
  output logic                     gt
);

  // An empty cell counts as larger than anything, so the new value lands
  // in the first free place when nothing held is larger.
  assign gt = !occupied || (value > new_value);

  always_ff @(posedge clk) begin
    if (ctrl.load && gt) begin
      value <= left_gt ? left_value : new_value;
    end else if (ctrl.shift_out) begin
      value <= right_value;
    end
  end

endmodule

/* hw/rtl/insertion_sorter.sv */
// Top level of the insertion sorter: cell chain, fill count and output stage.
// Depends on isort_pkg and isort_cell.
//
//   channel | direction | tdata              | tlast         | tuser
//   --------+-----------+--------------------+---------------+-------------
//   s_*     | in        | sample_value[31:0] | final_element | -
//   m_*     | out       | sorted_value[31:0] | end_of_set    | overflowed
//
// Each request is inserted as it is taken, and the next can be taken at once:
// every cell compares its entry with the broadcast value in parallel and the
// row opens a gap at the insertion point. After the final request the row
// drains through cell zero, one result per cycle while m_tready is high, and
// s_tready is low for the whole drain.
// Reset clears the fill count, the drop flag and the control; the row itself
// is not cleared, since only filled places are ever read.
module insertion_sorter
  import isort_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [31:0] sample_value
  input  logic              s_tlast,   // final_element
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
  output logic              m_tlast,   // end_of_set
  output logic [0:0]        m_tuser    // [0] overflowed
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // Two modes: taking in elements, and handing the sorted set out.
  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic             state;
  logic [CNT_W-1:0] count;      // entries held in the row
  logic             dropped;    // an element of the current set was dropped
  logic [CNT_W-1:0] remaining;  // results still to leave the row
  logic             set_ovf;    // overflow mark of the set being drained

  logic       accept;
  logic       full;
  logic       drain_step;
  cell_ctrl_t ctrl;

  logic signed [DATA_W-1:0] cell_value [MAX_ITEMS];
  logic                     cell_gt    [MAX_ITEMS];

  assign s_tready   = (state == ST_LOAD);
  assign accept     = s_tvalid && s_tready;
  assign full       = (count == CNT_W'(MAX_ITEMS));
  // While draining with results left, the row moves one place whenever the output register is free or emptying.
  assign drain_step = (state == ST_DRAIN) && (remaining != '0) && (!m_tvalid || m_tready);

  assign ctrl.load      = accept && !full;
  assign ctrl.shift_out = drain_step;

  // The chain: each cell sees its left neighbor for inserts and its right
  // neighbor for the drain. Cell zero has no left neighbor larger than the
  // new value; the last cell simply keeps its own entry while draining.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                     l_gt;
    logic signed [DATA_W-1:0] l_value;
    logic signed [DATA_W-1:0] r_value;

    if (i == 0) begin : g_first
      assign l_gt    = 1'b0;
      assign l_value = cell_value[0];
    end else begin : g_inner
      assign l_gt    = cell_gt[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign r_value = cell_value[i];
    end else begin : g_mid
      assign r_value = cell_value[i+1];
    end

    isort_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (CNT_W'(i) < count),
      .new_value   ($signed(s_tdata)),
      .left_gt     (l_gt),
      .left_value  (l_value),
      .right_value (r_value),
      .value       (cell_value[i]),
      .gt          (cell_gt[i])
    );
  end

  // Fill count, drop flag, mode, results remaining and overflow mark of the set.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      remaining <= '0;
      set_ovf   <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (s_tlast) begin
              // The set is complete: hand over its size and overflow mark.
              state     <= ST_DRAIN;
              remaining <= full ? count : count + CNT_W'(1);
              set_ovf   <= dropped || full;
              count     <= '0;
              dropped   <= 1'b0;
            end else if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (drain_step) begin
            remaining <= remaining - CNT_W'(1);
            if (remaining == CNT_W'(1)) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Output register: the smallest entry leaves from cell zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (drain_step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_step) begin
      m_tdata    <= cell_value[0];
      m_tlast    <= (remaining == CNT_W'(1));
      m_tuser[0] <= set_ovf;
    end
  end

endmodule

/* hw/rtl/isort_checker.sv */
// Port-level checker for the insertion sorter, bound to the top level.
// Depends on assert_macros.svh and insertion_sorter.
`include "assert_macros.svh"

module isort_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic [0:0]  m_tuser
);

  // A stalled result holds its value.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // No new element is taken once a set has closed.
  `ASSERT_NEXT(a_close_stall, clk, rst, s_tvalid && s_tready && s_tlast, !s_tready)

  // While a set is still leaving, the input stays closed.
  `ASSERT_IMPLIES(a_drain_stall, clk, rst, m_tvalid && !m_tlast, !s_tready)

  // Results within a set are ascending and share one overflow mark.
  `ASSERT_IMPLIES(a_ascending, clk, rst,
    $past(!rst) && $past(m_tvalid && m_tready && !m_tlast),
    m_tvalid && ($signed(m_tdata) >= $signed($past(m_tdata))) &&
    (m_tuser == $past(m_tuser)))

endmodule

bind insertion_sorter isort_checker u_isort_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
